// File: rtl/core/lphm_pkg.sv
// Package for the linear probe hash map: payload structs, operation and status codes.
// Used by lphm_store and linear_probe_hash_map; depends on nothing else.
package lphm_pkg;

    // Physical table depth; the result fields are sized for it.
    localparam int SLOTS = 1024;

    localparam logic [1:0] FUNC_FIND   = 2'd0;
    localparam logic [1:0] FUNC_ADD    = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ABSENT  = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] key;
        logic [31:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_value;
        logic [9:0]  slot_index;
        logic [10:0] entry_count;
    } rsp_t;

    // Memory command from the sequencer to the slot store.
    typedef struct packed {
        logic        rd;
        logic        wr;
        logic [31:0] wkey;
        logic [31:0] wval;
    } mem_cmd_t;

endpackage

// File: rtl/core/lphm_store.sv
// Slot store: key and value memories with registered read.
// Key validity is tracked by a clearing sweep after reset. Depends on lphm_pkg.
module lphm_store #(
    parameter int SLOTS = 1024,
    parameter int AW    = 10
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  lphm_pkg::mem_cmd_t cmd,
    input  logic [AW-1:0]      raddr,
    input  logic [AW-1:0]      waddr,
    output logic [31:0]        rkey,
    output logic [31:0]        rval,
    output logic               clr_busy
);
    logic [31:0]   key_mem [SLOTS];
    logic [31:0]   val_mem [SLOTS];
    logic [AW:0]   clr_reg;

    assign clr_busy = !clr_reg[AW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (clr_busy) begin
            clr_reg <= (clr_reg[AW-1:0] == AW'(SLOTS - 1)) ? {1'b1, {AW{1'b0}}}
                                                          : clr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy) begin
            key_mem[clr_reg[AW-1:0]] <= '0;
            val_mem[clr_reg[AW-1:0]] <= '0;
        end else if (cmd.wr) begin
            key_mem[waddr] <= cmd.wkey;
            val_mem[waddr] <= cmd.wval;
        end
        if (cmd.rd) begin
            rkey <= key_mem[raddr];
            rval <= val_mem[raddr];
        end
    end
endmodule

// File: rtl/core/lphm_mod.sv
// Iterative key modulo unit: one quotient bit per cycle (restoring division).
// Depends on nothing outside this file.
module lphm_mod #(
    parameter int NW = 11
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [31:0]   dividend,
    input  logic [NW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] remainder
);
    logic [NW-1:0] rem_reg;
    logic [31:0]   dvd_reg;
    logic [5:0]    cnt_reg;
    logic          busy_reg;
    logic [NW:0]   trial;
    logic [NW+1:0] diff;

    assign trial = {rem_reg, dvd_reg[31]};
    assign diff  = {1'b0, trial} - {2'b0, divisor};
    assign remainder = rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 6'd31) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    // The partial remainder stays below the divisor, so NW bits hold it.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dvd_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= diff[NW+1] ? trial[NW-1:0] : diff[NW-1:0];
            dvd_reg <= {dvd_reg[30:0], 1'b0};
        end
    end
endmodule

// File: rtl/core/linear_probe_hash_map.sv
// Top level of the linear probe hash map: handshake, probe sequencer, count register.
// Depends on lphm_pkg, lphm_store and lphm_mod.
//
//  channel   | ports                         | direction | payload
//  input     | s_valid, s_ready, s_data      | in        | lphm_pkg::req_t
//  result    | m_valid, m_ready, m_data      | out       | lphm_pkg::rsp_t
//  config    | cfg_we, cfg_wdata             | in        | slots_in_use[10:0]
//
// One transaction at a time. Zero key or unused code: straight to the response state after accept.
// Otherwise the key passes the bit-serial modulo, then each probed slot is read and compared.
// Remove then walks its cluster: each entry is read, rehashed and probed for, and moved
// when a free slot comes first; the empty slot that ends the walk is read as well.
// After reset the slot memory is swept clear while s_ready is low.
// The result waits in an output register; the core stalls only if a new result is ready before the last is taken.
module linear_probe_hash_map (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  lphm_pkg::req_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output lphm_pkg::rsp_t   m_data,
    input  logic             cfg_we,
    input  logic [10:0]      cfg_wdata
);
    localparam int SLOTS = lphm_pkg::SLOTS;
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NW = $clog2(SLOTS + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HASH  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_CMP   = 4'd3;
    localparam logic [3:0] S_DONE  = 4'd4;
    localparam logic [3:0] S_WRD   = 4'd5;
    localparam logic [3:0] S_WCMP  = 4'd6;
    localparam logic [3:0] S_WHASH = 4'd7;
    localparam logic [3:0] S_WPRD  = 4'd8;
    localparam logic [3:0] S_WPCMP = 4'd9;
    localparam logic [3:0] S_RESP  = 4'd10;

    logic [3:0]       state_reg;
    logic [10:0]      cfg_reg;
    logic [NW-1:0]    n_reg;
    lphm_pkg::req_t   req_reg;
    logic [AW-1:0]    idx_reg;     // probe pointer
    logic [NW-1:0]    cnt_reg;     // probes done
    logic [AW-1:0]    cur_reg;     // walk pointer
    logic [31:0]      wkey_reg;
    logic [31:0]      wval_reg;
    logic [NW-1:0]    occ_reg;
    lphm_pkg::rsp_t   rsp_reg;
    lphm_pkg::rsp_t   mdata_reg;
    logic             mvalid_reg;

    lphm_pkg::mem_cmd_t cmd;
    logic [AW-1:0]    raddr, waddr;
    logic [31:0]      rkey, rval;
    logic             clr_busy;
    logic             mod_start, mod_done;
    logic [NW-1:0]    mod_rem;
    logic [31:0]      mod_dvd;
    logic [NW-1:0]    n_eff;
    logic [AW-1:0]    idx_inc, cur_inc;

    always_comb begin
        if (cfg_reg == 11'd0)                 n_eff = NW'(1);
        else if ({21'd0, cfg_reg} > SLOTS)    n_eff = NW'(SLOTS);
        else                                  n_eff = NW'(cfg_reg);
    end

    assign idx_inc = ({1'b0, idx_reg} + 1'b1 >= (AW+1)'(n_reg)) ? '0 : idx_reg + 1'b1;
    assign cur_inc = ({1'b0, cur_reg} + 1'b1 >= (AW+1)'(n_reg)) ? '0 : cur_reg + 1'b1;

    assign s_ready = (state_reg == S_IDLE) && !clr_busy;
    assign m_valid = mvalid_reg;
    assign m_data  = mdata_reg;

    lphm_store #(.SLOTS(SLOTS), .AW(AW)) u_store (
        .aclk, .aresetn, .cmd, .raddr, .waddr, .rkey, .rval, .clr_busy
    );

    lphm_mod #(.NW(NW)) u_mod (
        .aclk, .aresetn, .start(mod_start), .dividend(mod_dvd), .divisor(n_reg),
        .done(mod_done), .remainder(mod_rem)
    );

    always_comb begin
        cmd       = '0;
        raddr     = idx_reg;
        waddr     = idx_reg;
        mod_start = 1'b0;
        mod_dvd   = req_reg.key;
        unique case (state_reg)
            S_HASH:  ;
            S_RD:    cmd.rd = 1'b1;
            S_WRD:   begin cmd.rd = 1'b1; raddr = cur_reg; end
            S_WPRD:  cmd.rd = 1'b1;
            S_WHASH: mod_dvd = wkey_reg;
            default: ;
        endcase
        if (state_reg == S_IDLE && s_valid && s_ready
            && s_data.key != 32'd0 && s_data.func <= lphm_pkg::FUNC_REMOVE) begin
            mod_start = 1'b1;
            mod_dvd   = s_data.key;
        end
        if (state_reg == S_WCMP && rkey != 32'd0) begin
            mod_start = 1'b1;
            mod_dvd   = rkey;
        end
        // writes
        if (state_reg == S_CMP && (rkey == 32'd0 || rkey == req_reg.key)) begin
            if (req_reg.func == lphm_pkg::FUNC_ADD) begin
                cmd.wr = 1'b1; cmd.wkey = req_reg.key; cmd.wval = req_reg.value;
            end else if (req_reg.func == lphm_pkg::FUNC_REMOVE && rkey != 32'd0) begin
                cmd.wr = 1'b1;
            end
        end
        if (state_reg == S_WPCMP && (rkey == 32'd0 || rkey == wkey_reg)
            && idx_reg != cur_reg) begin
            cmd.wr = 1'b1; cmd.wkey = wkey_reg; cmd.wval = wval_reg;
        end
        if (state_reg == S_WPRD && cnt_reg == '1) begin
            // clear the old slot after a move
            cmd.wr = 1'b1; waddr = cur_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            cfg_reg    <= 11'(SLOTS);
            occ_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) cfg_reg <= cfg_wdata;
            if (state_reg == S_RESP && (!mvalid_reg || m_ready)) mvalid_reg <= 1'b1;
            else if (m_ready)                                    mvalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        req_reg <= s_data;
                        n_reg   <= n_eff;
                        cnt_reg <= '0;
                        rsp_reg <= '{lphm_pkg::ST_ABSENT, 32'd0, 10'd0, 11'(occ_reg)};
                        if (mod_start) state_reg <= S_HASH;
                        else           state_reg <= S_RESP;
                    end
                end
                S_HASH: if (mod_done) begin
                    idx_reg   <= AW'(mod_rem);
                    state_reg <= S_RD;
                end
                S_RD: state_reg <= S_CMP;
                S_CMP: begin
                    if (rkey == 32'd0 || rkey == req_reg.key) begin
                        state_reg <= S_RESP;
                        if (req_reg.func == lphm_pkg::FUNC_ADD) begin
                            rsp_reg.status     <= lphm_pkg::ST_OK;
                            rsp_reg.slot_index <= 10'(idx_reg);
                            if (rkey == 32'd0) begin
                                occ_reg             <= occ_reg + 1'b1;
                                rsp_reg.entry_count <= 11'(occ_reg + 1'b1);
                            end
                        end else if (rkey != 32'd0) begin
                            rsp_reg.status     <= lphm_pkg::ST_OK;
                            rsp_reg.slot_index <= 10'(idx_reg);
                            if (req_reg.func == lphm_pkg::FUNC_FIND) begin
                                rsp_reg.found_value <= rval;
                            end else begin
                                if (occ_reg != '0) begin
                                    occ_reg             <= occ_reg - 1'b1;
                                    rsp_reg.entry_count <= 11'(occ_reg - 1'b1);
                                end
                                cur_reg   <= idx_inc;
                                state_reg <= S_WRD;
                            end
                        end
                    end else if (cnt_reg + 1'b1 == n_reg) begin
                        if (req_reg.func == lphm_pkg::FUNC_ADD)
                            rsp_reg.status <= lphm_pkg::ST_FULL;
                        state_reg <= S_RESP;
                    end else begin
                        cnt_reg   <= cnt_reg + 1'b1;
                        idx_reg   <= idx_inc;
                        state_reg <= S_RD;
                    end
                end
                S_WRD: state_reg <= S_WCMP;
                S_WCMP: begin
                    if (rkey == 32'd0) begin
                        state_reg <= S_RESP;
                    end else begin
                        wkey_reg  <= rkey;
                        wval_reg  <= rval;
                        cnt_reg   <= '0;
                        state_reg <= S_WHASH;
                    end
                end
                S_WHASH: if (mod_done) begin
                    idx_reg   <= AW'(mod_rem);
                    state_reg <= S_WPRD;
                end
                S_WPRD: begin
                    if (cnt_reg == '1) begin
                        // old slot cleared this cycle; move on
                        cur_reg   <= cur_inc;
                        state_reg <= S_WRD;
                    end else begin
                        state_reg <= S_WPCMP;
                    end
                end
                S_WPCMP: begin
                    if (rkey == 32'd0 || rkey == wkey_reg) begin
                        if (idx_reg != cur_reg) begin
                            cnt_reg   <= '1;
                            state_reg <= S_WPRD;
                        end else begin
                            cur_reg   <= cur_inc;
                            state_reg <= S_WRD;
                        end
                    end else begin
                        cnt_reg   <= cnt_reg + 1'b1;
                        idx_reg   <= idx_inc;
                        state_reg <= S_WPRD;
                    end
                end
                S_RESP: begin
                    // hold until the output register is free
                    if (!mvalid_reg || m_ready) begin
                        mdata_reg <= rsp_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // The entry count never exceeds the table depth.
    a_occ_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {21'd0, occ_reg} <= SLOTS)
        else $error("entry count beyond table depth");

    // No transaction is taken while the clearing sweep runs.
    a_no_accept_clr: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> !s_ready)
        else $error("input accepted during clear sweep");

    // A result is only raised from the response state.
    a_resp_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg) == S_RESP)
        else $error("result raised outside response state");
endmodule
